// ----- src/gqm_pkg.sv -----
// gqm_pkg: shared constants and types for the greedy quad merge plane
// depends on nothing; imported by every module of the block

package gqm_pkg;

   localparam int PLANE_SIZE_DEF = 16;
   localparam int TYPE_BITS_DEF  = 8;

   localparam int ROW_W   = 4;
   localparam int COL_W   = 4;
   localparam int CTYPE_W = 8;
   localparam int QSIZE_W = 5;
   localparam int NORM_W  = 3;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUAD  = 1'b1;

   localparam logic REG_FACE_NORMAL = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_LEAD = 5'b00100,
      ST_CHK  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

endpackage

// ----- src/greedy_quad_merge_plane.sv -----
// greedy_quad_merge_plane: top level, sequencer and plane bit maps
// uses gqm_pkg, gqm_type_mem, gqm_span_unit
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      action, cell_row, cell_col, cell_exposed, cell_type
//   rsp_      out        valid / stall      quad_col .. quad_normal, done_res
//   apb       in         psel/penable       face_normal at address 0
//
// a quad transaction scans rows from the scan position, reads the lead row, then checks
// the rows below the quad; the scan steps one row a cycle through the bit maps and the
// downward check one row a cycle through the row-wide type memory
// reset clears maps, scan position and normal; no clearing pass is needed
// a waiting result does not block the next write; a quad result waits for the output slot

module greedy_quad_merge_plane #(
   parameter int PLANE_SIZE = gqm_pkg::PLANE_SIZE_DEF,
   parameter int TYPE_BITS  = gqm_pkg::TYPE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [gqm_pkg::ROW_W-1:0]      req_cell_row,
   input  logic [gqm_pkg::COL_W-1:0]      req_cell_col,
   input  logic                           req_cell_exposed,
   input  logic [gqm_pkg::CTYPE_W-1:0]    req_cell_type,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gqm_pkg::COL_W-1:0]      rsp_quad_col,
   output logic [gqm_pkg::ROW_W-1:0]      rsp_quad_row,
   output logic [gqm_pkg::QSIZE_W-1:0]    rsp_quad_width,
   output logic [gqm_pkg::QSIZE_W-1:0]    rsp_quad_height,
   output logic [gqm_pkg::CTYPE_W-1:0]    rsp_quad_type,
   output logic [gqm_pkg::NORM_W-1:0]     rsp_quad_normal,
   output logic                           rsp_done_res,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gqm_pkg::ADDR_W-1:0]     paddr,
   input  logic [gqm_pkg::DATA_W-1:0]     pwdata,
   output logic [gqm_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);
   import gqm_pkg::*;

   localparam int IDX_W = $clog2(PLANE_SIZE);
   localparam int W_W   = $clog2(PLANE_SIZE + 1);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(PLANE_SIZE - 1);

   state_type state_ff, state_in;

   logic [PLANE_SIZE-1:0] exposed_ff [PLANE_SIZE];
   logic [PLANE_SIZE-1:0] merged_ff  [PLANE_SIZE];

   logic [IDX_W-1:0]     scan_row_ff, scan_row_in;
   logic [IDX_W-1:0]     scan_col_ff, scan_col_in;
   logic                 scan_end_ff, scan_end_in;
   logic [IDX_W-1:0]     quad_row_ff, quad_row_in;
   logic [IDX_W-1:0]     quad_col_ff, quad_col_in;
   logic [IDX_W-1:0]     chk_row_ff, chk_row_in;
   logic [W_W-1:0]       width_ff, width_in;
   logic [W_W-1:0]       height_ff, height_in;
   logic [PLANE_SIZE-1:0] span_ff, span_in;
   logic [TYPE_BITS-1:0] lead_ff, lead_in;
   logic                 done_ff, done_in;
   logic [NORM_W-1:0]    normal_ff;

   logic                 rsp_valid_ff;
   logic [COL_W-1:0]     rsp_col_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [QSIZE_W-1:0]   rsp_width_ff;
   logic [QSIZE_W-1:0]   rsp_height_ff;
   logic [CTYPE_W-1:0]   rsp_type_ff;
   logic [NORM_W-1:0]    rsp_normal_ff;
   logic                 rsp_done_ff;

   logic                 req_take;
   logic                 wr_cell;
   logic                 out_load;
   logic [IDX_W-1:0]     wr_row;
   logic [IDX_W-1:0]     wr_col;
   logic [IDX_W-1:0]     cur_row;
   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_row;
   logic [TYPE_BITS-1:0] type_row [PLANE_SIZE];
   logic [TYPE_BITS-1:0] lead_sel;
   logic [PLANE_SIZE-1:0] open_mask;
   logic [W_W-1:0]       run_width;
   logic [PLANE_SIZE-1:0] run_span;
   logic [PLANE_SIZE-1:0] cand;
   logic                 cand_any;
   logic [IDX_W-1:0]     cand_col;
   logic                 mark_en;
   logic                 row_fits;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign wr_row    = IDX_W'(req_cell_row);
   assign wr_col    = IDX_W'(req_cell_col);
   assign wr_cell   = req_take && (req_action == ACT_WRITE)
                      && (int'(req_cell_row) < PLANE_SIZE) && (int'(req_cell_col) < PLANE_SIZE);
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // one shared row read port into the bit maps
   always_comb begin
      unique case (state_ff)
         ST_LEAD: cur_row = quad_row_ff;
         ST_CHK:  cur_row = chk_row_ff;
         default: cur_row = scan_row_ff;
      endcase
   end

   // first exposed, unmerged cell at or after the scan column
   always_comb begin
      for (int i = 0; i < PLANE_SIZE; i++) begin
         cand[i] = exposed_ff[cur_row][i] & ~merged_ff[cur_row][i] & (i >= int'(scan_col_ff));
      end
      cand_any = |cand;
      cand_col = '0;
      for (int i = PLANE_SIZE - 1; i >= 0; i--) begin
         if (cand[i]) begin
            cand_col = IDX_W'(i);
         end
      end
   end

   assign lead_sel = (state_ff == ST_LEAD) ? type_row[quad_col_ff] : lead_ff;
   assign row_fits = ((open_mask & span_ff) == span_ff);

   gqm_type_mem #(
      .PLANE_SIZE(PLANE_SIZE),
      .TYPE_BITS (TYPE_BITS)
   ) u_type_mem (
      .clock  (clock),
      .wr_en  (wr_cell),
      .wr_row (wr_row),
      .wr_col (wr_col),
      .wr_data(TYPE_BITS'(req_cell_type)),
      .rd_en  (mem_rd_en),
      .rd_row (mem_rd_row),
      .rd_data(type_row)
   );

   gqm_span_unit #(
      .PLANE_SIZE(PLANE_SIZE),
      .TYPE_BITS (TYPE_BITS)
   ) u_span (
      .exposed_row(exposed_ff[cur_row]),
      .merged_row (merged_ff[cur_row]),
      .type_row   (type_row),
      .lead       (lead_sel),
      .start_col  (quad_col_ff),
      .open_mask  (open_mask),
      .run_width  (run_width),
      .run_span   (run_span)
   );

   always_comb begin
      state_in    = state_ff;
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      scan_end_in = scan_end_ff;
      quad_row_in = quad_row_ff;
      quad_col_in = quad_col_ff;
      chk_row_in  = chk_row_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      span_in     = span_ff;
      lead_in     = lead_ff;
      done_in     = done_ff;
      mem_rd_en   = 1'b0;
      mem_rd_row  = scan_row_ff;
      mark_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_WRITE) begin
                  scan_row_in = '0;
                  scan_col_in = '0;
                  scan_end_in = 1'b0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end_ff) begin
               done_in  = 1'b1;
               state_in = ST_OUT;
            end else if (cand_any) begin
               quad_row_in = scan_row_ff;
               quad_col_in = cand_col;
               mem_rd_en   = 1'b1;
               mem_rd_row  = scan_row_ff;
               done_in     = 1'b0;
               state_in    = ST_LEAD;
            end else if (scan_row_ff == LAST) begin
               scan_end_in = 1'b1;
               done_in     = 1'b1;
               state_in    = ST_OUT;
            end else begin
               scan_row_in = scan_row_ff + 1'b1;
               scan_col_in = '0;
            end
         end
         ST_LEAD: begin
            lead_in   = lead_sel;
            width_in  = run_width;
            span_in   = run_span;
            height_in = W_W'(1);
            mark_en   = 1'b1;
            if (quad_row_ff == LAST) begin
               state_in = ST_OUT;
            end else begin
               chk_row_in = quad_row_ff + 1'b1;
               mem_rd_en  = 1'b1;
               mem_rd_row = quad_row_ff + 1'b1;
               state_in   = ST_CHK;
            end
         end
         ST_CHK: begin
            if (row_fits) begin
               mark_en   = 1'b1;
               height_in = height_ff + 1'b1;
               if (chk_row_ff == LAST) begin
                  state_in = ST_OUT;
               end else begin
                  chk_row_in = chk_row_ff + 1'b1;
                  mem_rd_en  = 1'b1;
                  mem_rd_row = chk_row_ff + 1'b1;
               end
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
               if (!done_ff) begin
                  // resume just after the top-left cell of this quad
                  if (quad_col_ff == LAST) begin
                     scan_col_in = '0;
                     if (quad_row_ff == LAST) begin
                        scan_end_in = 1'b1;
                     end else begin
                        scan_row_in = quad_row_ff + 1'b1;
                     end
                  end else begin
                     scan_row_in = quad_row_ff;
                     scan_col_in = quad_col_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         scan_end_ff  <= 1'b0;
         done_ff      <= 1'b0;
         normal_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PLANE_SIZE; i++) begin
            exposed_ff[i] <= '0;
            merged_ff[i]  <= '0;
         end
      end else begin
         state_ff    <= state_in;
         scan_row_ff <= scan_row_in;
         scan_col_ff <= scan_col_in;
         scan_end_ff <= scan_end_in;
         done_ff     <= done_in;
         if (psel && penable && pwrite && pready && (paddr[2] == REG_FACE_NORMAL)) begin
            normal_ff <= pwdata[NORM_W-1:0];
         end
         if (wr_cell) begin
            exposed_ff[wr_row][wr_col] <= req_cell_exposed;
         end
         if (req_take && (req_action == ACT_WRITE)) begin
            for (int i = 0; i < PLANE_SIZE; i++) begin
               merged_ff[i] <= '0;
            end
         end else if (mark_en) begin
            merged_ff[cur_row] <= merged_ff[cur_row] | ((state_ff == ST_LEAD) ? run_span : span_ff);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quad_row_ff <= quad_row_in;
      quad_col_ff <= quad_col_in;
      chk_row_ff  <= chk_row_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      span_ff     <= span_in;
      lead_ff     <= lead_in;
      if (out_load) begin
         rsp_done_ff <= done_ff;
         if (done_ff) begin
            rsp_col_ff    <= '0;
            rsp_row_ff    <= '0;
            rsp_width_ff  <= '0;
            rsp_height_ff <= '0;
            rsp_type_ff   <= '0;
            rsp_normal_ff <= '0;
         end else begin
            rsp_col_ff    <= COL_W'(quad_col_ff);
            rsp_row_ff    <= ROW_W'(quad_row_ff);
            rsp_width_ff  <= QSIZE_W'(width_ff);
            rsp_height_ff <= QSIZE_W'(height_ff);
            rsp_type_ff   <= CTYPE_W'(lead_ff);
            rsp_normal_ff <= normal_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quad_col    = rsp_col_ff;
   assign rsp_quad_row    = rsp_row_ff;
   assign rsp_quad_width  = rsp_width_ff;
   assign rsp_quad_height = rsp_height_ff;
   assign rsp_quad_type   = rsp_type_ff;
   assign rsp_quad_normal = rsp_normal_ff;
   assign rsp_done_res    = rsp_done_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_FACE_NORMAL) ? DATA_W'(normal_ff) : '0;

endmodule

// ----- src/gqm_type_mem.sv -----
// gqm_type_mem: block type store, one row of cells per word
// per-cell write lane, registered row read; uses gqm_pkg

module gqm_type_mem #(
   parameter int PLANE_SIZE = gqm_pkg::PLANE_SIZE_DEF,
   parameter int TYPE_BITS  = gqm_pkg::TYPE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(PLANE_SIZE)-1:0] wr_row,
   input  logic [$clog2(PLANE_SIZE)-1:0] wr_col,
   input  logic [TYPE_BITS-1:0]          wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(PLANE_SIZE)-1:0] rd_row,
   output logic [TYPE_BITS-1:0]          rd_data [PLANE_SIZE]
);
   import gqm_pkg::*;

   logic [TYPE_BITS-1:0] type_mem [PLANE_SIZE][PLANE_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         type_mem[wr_row][wr_col] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= type_mem[rd_row];
      end
   end

endmodule

// ----- src/gqm_span_unit.sv -----
// gqm_span_unit: per-column open test for one row and run length to the right
// purely combinational lanes; uses gqm_pkg

module gqm_span_unit #(
   parameter int PLANE_SIZE = gqm_pkg::PLANE_SIZE_DEF,
   parameter int TYPE_BITS  = gqm_pkg::TYPE_BITS_DEF
) (
   input  logic [PLANE_SIZE-1:0]           exposed_row,
   input  logic [PLANE_SIZE-1:0]           merged_row,
   input  logic [TYPE_BITS-1:0]            type_row [PLANE_SIZE],
   input  logic [TYPE_BITS-1:0]            lead,
   input  logic [$clog2(PLANE_SIZE)-1:0]   start_col,
   output logic [PLANE_SIZE-1:0]           open_mask,
   output logic [$clog2(PLANE_SIZE+1)-1:0] run_width,
   output logic [PLANE_SIZE-1:0]           run_span
);
   import gqm_pkg::*;

   localparam int W_W = $clog2(PLANE_SIZE + 1);

   logic [PLANE_SIZE:0] shifted;

   always_comb begin
      for (int i = 0; i < PLANE_SIZE; i++) begin
         open_mask[i] = exposed_row[i] & ~merged_row[i] & (type_row[i] == lead);
      end
      shifted = {1'b0, open_mask} >> start_col;
      // lowest zero at or above the start column ends the run
      run_width = W_W'(PLANE_SIZE);
      for (int i = PLANE_SIZE; i >= 0; i--) begin
         if (!shifted[i]) begin
            run_width = W_W'(i);
         end
      end
      for (int i = 0; i < PLANE_SIZE; i++) begin
         run_span[i] = (i >= int'(start_col)) && (i < int'(start_col) + int'(run_width));
      end
   end

endmodule

// ----- verif/gqm_checker.sv -----
// gqm_checker: watches the request, result and register ports of the quad merge plane,
// predicts each quad result and compares it; depends on gqm_pkg only
`timescale 1ns / 100ps

module gqm_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_action,
   input  logic [gqm_pkg::ROW_W-1:0]   req_cell_row,
   input  logic [gqm_pkg::COL_W-1:0]   req_cell_col,
   input  logic                        req_cell_exposed,
   input  logic [gqm_pkg::CTYPE_W-1:0] req_cell_type,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [gqm_pkg::COL_W-1:0]   rsp_quad_col,
   input  logic [gqm_pkg::ROW_W-1:0]   rsp_quad_row,
   input  logic [gqm_pkg::QSIZE_W-1:0] rsp_quad_width,
   input  logic [gqm_pkg::QSIZE_W-1:0] rsp_quad_height,
   input  logic [gqm_pkg::CTYPE_W-1:0] rsp_quad_type,
   input  logic [gqm_pkg::NORM_W-1:0]  rsp_quad_normal,
   input  logic                        rsp_done_res,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gqm_pkg::ADDR_W-1:0]  paddr,
   input  logic [gqm_pkg::DATA_W-1:0]  pwdata,
   input  logic                        pready,
   output int                          fail_count,
   output int                          quads_pending
);
   import gqm_pkg::*;

   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [QSIZE_W-1:0] width;
      logic [QSIZE_W-1:0] height;
      logic [CTYPE_W-1:0] ctype;
      logic [NORM_W-1:0]  normal;
      logic               done;
   } quad_rec_type;

   // expected results, ring of pending transactions
   quad_rec_type       exp_ring[64];
   int                 exp_wr;
   int                 exp_rd;

   logic               exposed_bits[16][16];
   logic               merged_bits[16][16];
   logic [CTYPE_W-1:0] cell_types[16][16];
   logic [NORM_W-1:0]  normal_reg;
   int                 scan_pos;

   function automatic logic is_open(int r, int c, logic [CTYPE_W-1:0] lead);
      return exposed_bits[r][c] && !merged_bits[r][c] && cell_types[r][c] == lead;
   endfunction

   task automatic merge_next_quad();
      int pos, r, c, w, h, k;
      logic ok;
      logic [CTYPE_W-1:0] lead;
      quad_rec_type q;
      q = '0;
      for (pos = scan_pos; pos < 256; pos++) begin
         if (exposed_bits[pos/16][pos%16] && !merged_bits[pos/16][pos%16]) break;
      end
      if (pos >= 256) begin
         scan_pos = 256;
         q.done = 1'b1;
      end else begin
         r = pos / 16;
         c = pos % 16;
         lead = cell_types[r][c];
         w = 1;
         while (c + w < 16 && is_open(r, c + w, lead)) w++;
         h = 1;
         ok = 1'b1;
         while (r + h < 16 && ok) begin
            for (k = 0; k < w; k++) if (!is_open(r + h, c + k, lead)) ok = 1'b0;
            if (ok) h++;
         end
         for (int i = 0; i < h; i++)
            for (k = 0; k < w; k++) merged_bits[r+i][c+k] = 1'b1;
         scan_pos = pos + 1;
         q.col = COL_W'(c);
         q.row = ROW_W'(r);
         q.width = QSIZE_W'(w);
         q.height = QSIZE_W'(h);
         q.ctype = lead;
         q.normal = normal_reg;
      end
      exp_ring[exp_wr % 64] = q;
      exp_wr++;
   endtask

   always @(posedge clock) begin
      quad_rec_type got, want;
      if (reset) begin
         normal_reg = '0;
         scan_pos = 0;
         exp_wr = 0;
         exp_rd = 0;
         fail_count = 0;
         for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++) begin
               exposed_bits[r][c] = 1'b0;
               merged_bits[r][c] = 1'b0;
               cell_types[r][c] = '0;
            end
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_FACE_NORMAL)
            normal_reg = pwdata[NORM_W-1:0];
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_quad_col, rsp_quad_row, rsp_quad_width, rsp_quad_height,
                   rsp_quad_type, rsp_quad_normal, rsp_done_res};
            if (exp_wr == exp_rd) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result transaction %h", got);
            end else begin
               want = exp_ring[exp_rd % 64];
               exp_rd++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp col %0d row %0d w %0d h %0d type %0d nrm %0d done %0d",
                              want.col, want.row, want.width, want.height, want.ctype,
                              want.normal, want.done, "\n         got col %0d row %0d w %0d",
                              got.col, got.row, got.width, " h %0d type %0d nrm %0d done %0d",
                              got.height, got.ctype, got.normal, got.done);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACT_WRITE) begin
               exposed_bits[req_cell_row][req_cell_col] = req_cell_exposed;
               cell_types[req_cell_row][req_cell_col] = req_cell_type;
               for (int r = 0; r < 16; r++)
                  for (int c = 0; c < 16; c++) merged_bits[r][c] = 1'b0;
               scan_pos = 0;
            end else begin
               merge_next_quad();
            end
         end
      end
      quads_pending = exp_wr - exp_rd;
   end

endmodule

// ----- verif/greedy_quad_merge_plane_tb.sv -----
// greedy_quad_merge_plane_tb: drives cell writes, quad requests and face normal writes
// into the block; depends on gqm_pkg, greedy_quad_merge_plane and gqm_checker
`timescale 1ns / 100ps

module greedy_quad_merge_plane_tb;
   import gqm_pkg::*;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_action;
   logic [ROW_W-1:0]    req_cell_row;
   logic [COL_W-1:0]    req_cell_col;
   logic                req_cell_exposed;
   logic [CTYPE_W-1:0]  req_cell_type;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [COL_W-1:0]    rsp_quad_col;
   logic [ROW_W-1:0]    rsp_quad_row;
   logic [QSIZE_W-1:0]  rsp_quad_width;
   logic [QSIZE_W-1:0]  rsp_quad_height;
   logic [CTYPE_W-1:0]  rsp_quad_type;
   logic [NORM_W-1:0]   rsp_quad_normal;
   logic                rsp_done_res;
   logic                psel, penable, pwrite, pready;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata, prdata;
   int                  fail_count, quads_pending;
   int                  items_sent, burst_left;

   always #5 clock = ~clock;

   greedy_quad_merge_plane uut (.*);

   gqm_checker u_checker (.*);

   // receiver: stall mode is redrawn at random, with one long hold-off early on
   int stall_cycle = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (reset) rsp_stall <= 1'b0;
      else if (stall_cycle >= 3000 && stall_cycle < 3400) rsp_stall <= 1'b1;
      else case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_cycle[3];
      endcase
   end

   task automatic send_item(logic act, logic [3:0] r, logic [3:0] c, logic ex,
                            logic [7:0] ty);
      req_valid <= 1'b1;
      req_action <= act;
      req_cell_row <= r;
      req_cell_col <= c;
      req_cell_exposed <= ex;
      req_cell_type <= ty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (burst_left > 0) burst_left--;
      else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   // register writes only with the block idle; a trailing write gives no result
   task automatic set_normal(logic [2:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (quads_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_FACE_NORMAL, 2'b00};
      pwdata <= {29'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int n_writes, n_quads, span, r0, c0;
      logic [7:0] pal0, pal1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_WRITE;
      req_cell_row <= '0;
      req_cell_col <= '0;
      req_cell_exposed <= 1'b0;
      req_cell_type <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      items_sent = 0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full-width row, done twice, exposed-zero write, extremes
      set_normal(3'd5);
      for (int c = 0; c < 16; c++) send_item(ACT_WRITE, 4'd0, c[3:0], 1'b1, 8'hff);
      send_item(ACT_QUAD, 4'd0, 4'd0, 1'b0, 8'h00);
      send_item(ACT_QUAD, 4'd15, 4'd15, 1'b1, 8'hff);
      send_item(ACT_QUAD, 4'd0, 4'd0, 1'b0, 8'h00);
      send_item(ACT_WRITE, 4'd15, 4'd15, 1'b1, 8'h00);
      send_item(ACT_WRITE, 4'd0, 4'd3, 1'b0, 8'h5a);
      repeat (4) send_item(ACT_QUAD, 4'd0, 4'd0, 1'b0, 8'h00);

      while (items_sent < 950) begin
         case ($urandom_range(0, 3))
            0: set_normal(3'd0);
            1: set_normal(3'd5);
            default: set_normal(3'($urandom_range(0, 5)));
         endcase
         span = $urandom_range(2, 16);
         r0 = $urandom_range(0, 16 - span);
         c0 = $urandom_range(0, 16 - span);
         pal0 = 8'($urandom);
         pal1 = ($urandom_range(0, 1)) ? pal0 : 8'($urandom);
         n_writes = $urandom_range(1, 30);
         for (int i = 0; i < n_writes; i++)
            send_item(ACT_WRITE, 4'(r0 + $urandom_range(0, span - 1)),
                      4'(c0 + $urandom_range(0, span - 1)),
                      $urandom_range(0, 9) != 0,
                      ($urandom_range(0, 3) == 0) ? pal1 : pal0);
         n_quads = n_writes + 2;
         for (int i = 0; i < n_quads; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_item(ACT_WRITE, 4'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
            else
               send_item(ACT_QUAD, 4'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (quads_pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
